// ===== sv/pnc_pkg.sv =====
// Shared types and constants for the positive neighbour count block.
`timescale 1ns / 1ps

package pnc_pkg;

    localparam int MAX_COLS_DEF     = 128;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 4;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 2'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_DRAIN  = 1'b1;

    localparam logic [ROWS_W-1:0] FRAME_ROWS_RST = 16'd8;
    localparam logic [COLS_W-1:0] FRAME_COLS_RST = 8'd8;

    // window bit = row * 3 + col, row 0 on top, col 0 on the left
    localparam logic [8:0] MASK_NEIGHBOURS = 9'h1EF;
    localparam logic [8:0] MASK_TOP        = 9'h007;
    localparam logic [8:0] MASK_BOTTOM     = 9'h1C0;
    localparam logic [8:0] MASK_LEFT       = 9'h049;
    localparam logic [8:0] MASK_RIGHT      = 9'h124;
    localparam logic [8:0] WIN_KEEP        = 9'h0DB;

    // one column push for the back end
    typedef struct packed {
        logic       flag;
        logic       emit;
        logic       last;
        logic [8:0] mask;
    } t_op;

endpackage

// ===== sv/pnc_queue.sv =====
// Small register FIFO between the front and back ends.
`timescale 1ns / 1ps

module pnc_queue #(
    parameter int WIDTH = 16,
    parameter int DEPTH = pnc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             push_ok;
    logic             pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;
    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + NW'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count out of range");

endmodule

// ===== sv/pnc_front.sv =====
// Front end: config registers, frame counters and item classification.
`timescale 1ns / 1ps

module pnc_front #(
    parameter int MAX_COLS     = pnc_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_WIDTH = pnc_pkg::SAMPLE_WIDTH_DEF,
    parameter int CW           = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pnc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_item_valid,
    output logic                             o_item_ready,
    input  logic                             i_action,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample,
    output logic                             o_push,
    output pnc_pkg::t_op                     o_op,
    output logic [CW-1:0]                    o_addr,
    input  logic                             i_q_full,
    output logic                             o_restart
);

    localparam int ECW = CW + 1;
    localparam int EW  = (ECW > pnc_pkg::COLS_W) ? ECW : pnc_pkg::COLS_W;
    localparam int RW  = pnc_pkg::ROWS_W + 1;

    logic [pnc_pkg::ROWS_W-1:0] r_frame_rows;
    logic [pnc_pkg::COLS_W-1:0] r_frame_cols;
    logic [RW-1:0]              r_in_row,  n_in_row;
    logic [CW-1:0]              r_in_col,  n_in_col;
    logic [pnc_pkg::ROWS_W-1:0] r_out_row, n_out_row;
    logic [CW-1:0]              r_out_col, n_out_col;
    logic                       r_pend,    n_pend;

    logic [pnc_pkg::ROWS_W-1:0] rows_eff;
    logic [EW-1:0]              cols_wide;
    logic [EW-1:0]              cols_sat;
    logic [ECW-1:0]             cols_eff;
    logic                       complete;
    logic                       positive;
    logic                       item_fire;
    logic                       cfg_fire;
    logic                       col_ready;
    logic                       row_last;
    logic                       col_last;
    logic                       in_col_last;
    logic [8:0]                 mask;
    logic                       do_adv;
    logic                       flag;
    logic                       emit;
    logic                       last;

    assign rows_eff  = (r_frame_rows == '0) ? pnc_pkg::ROWS_W'(1) : r_frame_rows;
    assign cols_wide = EW'(r_frame_cols);
    assign cols_sat  = (cols_wide == '0) ? EW'(1) :
                       (cols_wide > EW'(MAX_COLS)) ? EW'(MAX_COLS) : cols_wide;
    assign cols_eff  = cols_sat[ECW-1:0];

    assign complete    = r_in_row >= {1'b0, rows_eff};
    assign positive    = (i_sample != '0) && !i_sample[SAMPLE_WIDTH-1];
    assign item_fire   = i_item_valid && o_item_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign col_ready   = (r_in_row >= RW'(2)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
    assign row_last    = ({1'b0, r_out_row} + RW'(1)) >= {1'b0, rows_eff};
    assign col_last    = ({1'b0, r_out_col} + ECW'(1)) >= cols_eff;
    assign in_col_last = ({1'b0, r_in_col} + ECW'(1)) >= cols_eff;

    always_comb begin
        mask = pnc_pkg::MASK_NEIGHBOURS;
        if (r_out_row == '0) begin
            mask = mask & ~pnc_pkg::MASK_TOP;
        end
        if (row_last) begin
            mask = mask & ~pnc_pkg::MASK_BOTTOM;
        end
        if (r_out_col == '0) begin
            mask = mask & ~pnc_pkg::MASK_LEFT;
        end
        if (col_last) begin
            mask = mask & ~pnc_pkg::MASK_RIGHT;
        end
    end

    // classify; a drain in a single-row frame may need a second column push
    always_comb begin
        do_adv = 1'b0;
        flag   = 1'b0;
        emit   = 1'b0;
        n_pend = r_pend;
        if (r_pend) begin
            if (!i_q_full) begin
                do_adv = 1'b1;
                emit   = 1'b1;
                n_pend = 1'b0;
            end
        end else if (item_fire) begin
            if (i_action == pnc_pkg::ACT_SAMPLE) begin
                if (!complete) begin
                    do_adv = 1'b1;
                    flag   = positive;
                    emit   = col_ready;
                end
            end else if (complete) begin
                do_adv = 1'b1;
                emit   = col_ready;
                n_pend = !col_ready;
            end
        end
    end

    assign last = emit && row_last && col_last;

    always_comb begin
        n_in_row  = r_in_row;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        if (do_adv) begin
            if (in_col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
        end
        if (emit) begin
            if (last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else if (col_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + pnc_pkg::ROWS_W'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end
    end

    assign o_restart = cfg_fire && ((i_cfg_index == pnc_pkg::CFG_FRAME_ROWS) ||
                                    (i_cfg_index == pnc_pkg::CFG_FRAME_COLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= pnc_pkg::FRAME_ROWS_RST;
            r_frame_cols <= pnc_pkg::FRAME_COLS_RST;
            r_in_row     <= '0;
            r_in_col     <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_pend       <= 1'b0;
        end else if (o_restart) begin
            if (i_cfg_index == pnc_pkg::CFG_FRAME_ROWS) begin
                r_frame_rows <= i_cfg_data[pnc_pkg::ROWS_W-1:0];
            end else begin
                r_frame_cols <= i_cfg_data[pnc_pkg::COLS_W-1:0];
            end
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_in_row  <= n_in_row;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
            r_pend    <= n_pend;
        end
    end

    assign o_cfg_ready  = 1'b1;
    assign o_item_ready = !r_pend && !i_q_full;
    assign o_push       = do_adv;
    assign o_addr       = r_in_col;
    assign o_op         = '{flag: flag, emit: emit, last: last, mask: mask};

    a_pend_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> complete)
        else $error("second drain push outside a complete frame");

    a_pend_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> col_ready)
        else $error("second drain push would not yield a result");

endmodule

// ===== sv/pnc_back.sv =====
// Back end: line store, 3x3 window, neighbour count and output register.
`timescale 1ns / 1ps

module pnc_back #(
    parameter int MAX_COLS = pnc_pkg::MAX_COLS_DEF,
    parameter int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic                          i_q_valid,
    input  pnc_pkg::t_op                  i_q_op,
    input  logic [CW-1:0]                 i_q_addr,
    output logic                          o_pop,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic [pnc_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_last
);

    // entry bit 1 = middle line, bit 0 = line above
    logic [1:0]                  r_mem [MAX_COLS];
    logic [1:0]                  r_line;
    logic                        r_s1_valid;
    pnc_pkg::t_op                r_s1_op;
    logic [CW-1:0]               r_s1_addr;
    logic [8:0]                  r_win;
    logic                        r_out_valid;
    logic [pnc_pkg::COUNT_W-1:0] r_out_count;
    logic                        r_out_last;

    logic                        s1_done;
    logic                        load;
    logic [8:0]                  n_win;
    logic [8:0]                  hits;
    logic [pnc_pkg::COUNT_W-1:0] count;

    assign s1_done = r_s1_valid && (!r_s1_op.emit || !r_out_valid || i_m_ready);
    assign load    = i_q_valid && (!r_s1_valid || s1_done);
    assign o_pop   = load;

    assign n_win = ((r_win >> 1) & pnc_pkg::WIN_KEEP) |
                   {r_s1_op.flag, 2'b00, r_line[1], 2'b00, r_line[0], 2'b00};
    assign hits  = n_win & r_s1_op.mask;

    always_comb begin
        count = '0;
        for (int i = 0; i < 9; i++) begin
            count = count + pnc_pkg::COUNT_W'(hits[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_mem[r_s1_addr] <= {r_s1_op.flag, r_line[1]};
        end
        if (load) begin
            // same column written this edge: take the new entry
            if (s1_done && (r_s1_addr == i_q_addr)) begin
                r_line <= {r_s1_op.flag, r_line[1]};
            end else begin
                r_line <= r_mem[i_q_addr];
            end
            r_s1_op   <= i_q_op;
            r_s1_addr <= i_q_addr;
        end
        if (s1_done && r_s1_op.emit) begin
            r_out_count <= count;
            r_out_last  <= r_s1_op.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (i_restart) begin
                r_win <= '0;
            end else if (s1_done) begin
                r_win <= r_s1_op.last ? '0 : n_win;
            end
            if (s1_done && r_s1_op.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_count   = r_out_count;
    assign o_last    = r_out_last;

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_op.last) |=> (r_win == '0))
        else $error("window not cleared after frame end");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_op.last) |-> r_s1_op.emit)
        else $error("frame end on a push without result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_done && r_s1_op.emit) |=> (r_out_count <= pnc_pkg::COUNT_W'(8)))
        else $error("neighbour count above eight");

endmodule

// ===== sv/positive_neighbour_count_3x3.sv =====
// Top level: positive 3x3 neighbour count over a raster stream.
// Path from the causing transaction to the result: queue, line store read and window
// stage, output register. A drain that needs two column pushes holds tready low until
// its second push is queued. One transaction per cycle while the queue is not full.
// Reset: frame_rows and frame_cols to 8, counters and window cleared; the line
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module positive_neighbour_count_3x3 #(
    parameter int MAX_COLS     = pnc_pkg::MAX_COLS_DEF,
    parameter int SAMPLE_WIDTH = pnc_pkg::SAMPLE_WIDTH_DEF,
    parameter int IN_DATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pnc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pnc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]               i_s_axis_tdata,  // sample
    input  logic                               i_s_axis_tuser,  // action
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [pnc_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // neighbour_count
    output logic                               o_m_axis_tlast
);

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int OPW = $bits(pnc_pkg::t_op);
    localparam int QW  = OPW + CW;

    logic                        push;
    pnc_pkg::t_op                push_op;
    logic [CW-1:0]               push_addr;
    logic                        q_full;
    logic                        q_valid;
    logic                        q_pop;
    logic [QW-1:0]               q_data;
    logic                        restart;
    logic [pnc_pkg::COUNT_W-1:0] count;

    pnc_front #(
        .MAX_COLS     (MAX_COLS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (o_s_axis_tready),
        .i_action     (i_s_axis_tuser),
        .i_sample     (i_s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .o_push       (push),
        .o_op         (push_op),
        .o_addr       (push_addr),
        .i_q_full     (q_full),
        .o_restart    (restart)
    );

    pnc_queue #(
        .WIDTH (QW),
        .DEPTH (pnc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_addr, push_op}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    pnc_back #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_q_valid (q_valid),
        .i_q_op    (pnc_pkg::t_op'(q_data[OPW-1:0])),
        .i_q_addr  (q_data[QW-1:OPW]),
        .o_pop     (q_pop),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_count   (count),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = pnc_pkg::OUT_DATA_W'(count);

endmodule
